// File: hdl/hd_pkg.sv
// hd_pkg: shared constants, codes and types for the Huffman tree decoder.
// No dependencies; every other file of the block but hd_ram imports it.
`default_nettype none

package hd_pkg;

  // Sizing of the node store and the code path
  localparam int MAX_NODES    = 512;
  localparam int MAX_CODE_LEN = 32;
  localparam int NODE_W       = $clog2(MAX_NODES);
  localparam int CNT_W        = $clog2(MAX_NODES + 1);

  // Fixed field widths of the channels
  localparam int OP_W     = 2;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int STATUS_W = 2;

  // Longest code walked by an insert
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // Symbol held by nodes that are not the end of a code
  localparam logic [SYM_W-1:0] INNER_MARK = 8'h23;

  // Command queue between front and back
  localparam int QPTR_W      = 1;
  localparam int QUEUE_DEPTH = 1 << QPTR_W;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_PATH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // One node of the code tree; a child of zero means no child
  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [SYM_W-1:0]  sym;
  } node_t;

  localparam int ENTRY_W = $bits(node_t);

  // Classified command as queued for the back end
  typedef struct packed {
    op_t               kind;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;     // code left aligned, first bit at the top
    logic [LEN_W-1:0]  len;      // saturated code length
    logic              bit_val;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic                symbol_valid;
    logic [SYM_W-1:0]    decoded_symbol;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/hd_in_if.sv
// hd_in_if: input channel of the decoder, valid/ready plus one command word.
// Depends on hd_pkg for field widths.
`default_nettype none

interface hd_in_if;
  import hd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              encoded_bit;

  modport source (
    output valid, operation, symbol, code_bits, code_length, encoded_bit,
    input  ready
  );

  modport sink (
    input  valid, operation, symbol, code_bits, code_length, encoded_bit,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/hd_out_if.sv
// hd_out_if: result channel of the decoder, valid/ready plus one result word.
// Depends on hd_pkg for field widths.
`default_nettype none

interface hd_out_if;
  import hd_pkg::*;

  logic                valid;
  logic                ready;
  logic                symbol_valid;
  logic [SYM_W-1:0]    decoded_symbol;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, symbol_valid, decoded_symbol, status,
    input  ready
  );

  modport sink (
    input  valid, symbol_valid, decoded_symbol, status,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/hd_ram.sv
// hd_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module hd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/hd_front.sv
// hd_front: accepts input words, classifies the operation, saturates and
// left-aligns the insert code. Depends on hd_pkg and hd_in_if.
`default_nettype none

module hd_front (
  hd_in_if.sink         item,
  input  logic          queue_full,
  output logic          push,
  output hd_pkg::cmd_t  cmd
);
  import hd_pkg::*;

  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] align_shift;

  // Take a word whenever the queue has room
  assign item.ready = !queue_full;
  assign push       = item.valid && !queue_full;

  // Clamp the code length and move the first code bit to the top
  assign len_sat     = (item.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                              : item.code_length;
  assign align_shift = LEN_W'(CODE_W) - len_sat;

  always_comb begin
    cmd.symbol  = item.symbol;
    cmd.code    = item.code_bits << align_shift;
    cmd.len     = len_sat;
    cmd.bit_val = item.encoded_bit;
    // Decode the operation field; unused codes map to OP_NONE
    case (item.operation)
      OP_W'(OP_CLEAR):  cmd.kind = OP_CLEAR;
      OP_W'(OP_INSERT): cmd.kind = OP_INSERT;
      OP_W'(OP_DECODE): cmd.kind = OP_DECODE;
      default:          cmd.kind = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/hd_queue.sv
// hd_queue: short FIFO of classified commands between front and back.
// Depends on hd_pkg.
`default_nettype none

module hd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hd_pkg::cmd_t  push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output hd_pkg::cmd_t  pop_cmd
);
  import hd_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hd_back.sv
// hd_back: executes clear, insert and decode against the node RAM and holds
// the result register. Depends on hd_pkg, hd_out_if and hd_ram.
`default_nettype none

module hd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  hd_pkg::cmd_t  cmd,
  output logic          pop,
  hd_out_if.source      result
);
  import hd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_STEP = 6'b000010,
    S_INS_RD   = 6'b000100,
    S_INS_LINK = 6'b001000,
    S_DEC_RD   = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  localparam node_t ROOT_BLANK = '{left: '0, right: '0, sym: INNER_MARK};

  state_t            state, state_next;
  logic [CNT_W-1:0]  nodes_used, nodes_used_next;
  logic [NODE_W-1:0] cur_node, cur_node_next;
  node_t             cur_entry, cur_entry_next;
  node_t             root_entry, root_entry_next;
  node_t             walk_entry, walk_entry_next;
  logic [NODE_W-1:0] walk_node, walk_node_next;
  node_t             link_entry, link_entry_next;
  logic [NODE_W-1:0] link_addr, link_addr_next;
  logic [CODE_W-1:0] shift_code, shift_code_next;
  logic [LEN_W-1:0]  remain, remain_next;
  logic [SYM_W-1:0]  ins_sym, ins_sym_next;
  logic [NODE_W-1:0] dec_child, dec_child_next;
  res_t              res, res_next;
  logic              out_valid, out_valid_next;
  res_t              out_res, out_res_next;

  logic               ram_we;
  logic [NODE_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [NODE_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  node_t              rd_entry;

  hd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = node_t'(ram_rdata);

  // Drive the result channel from the output register
  assign result.valid          = out_valid;
  assign result.symbol_valid   = out_res.symbol_valid;
  assign result.decoded_symbol = out_res.decoded_symbol;
  assign result.status         = out_res.status;

  // Sequence one command at a time
  always_comb begin
    node_t             cur_view;
    node_t             fresh;
    logic              step_bit;
    logic [NODE_W-1:0] slot;
    logic [NODE_W-1:0] child;
    logic [NODE_W-1:0] new_idx;

    state_next      = state;
    nodes_used_next = nodes_used;
    cur_node_next   = cur_node;
    cur_entry_next  = cur_entry;
    root_entry_next = root_entry;
    walk_entry_next = walk_entry;
    walk_node_next  = walk_node;
    link_entry_next = link_entry;
    link_addr_next  = link_addr;
    shift_code_next = shift_code;
    remain_next     = remain;
    ins_sym_next    = ins_sym;
    dec_child_next  = dec_child;
    res_next        = res;
    out_valid_next  = out_valid;
    out_res_next    = out_res;
    pop             = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    // Root entry lives in a register, other nodes come from the RAM read
    cur_view = (cur_node == '0) ? root_entry : cur_entry;
    child    = cmd.bit_val ? cur_view.right : cur_view.left;
    step_bit = shift_code[CODE_W-1];
    slot     = step_bit ? walk_entry.right : walk_entry.left;
    new_idx  = nodes_used[NODE_W-1:0];
    fresh.left  = '0;
    fresh.right = '0;
    fresh.sym   = (remain == LEN_W'(1)) ? ins_sym : INNER_MARK;

    // Drop the result once taken
    if (result.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          pop      = 1'b1;
          res_next = '0;
          case (cmd.kind)
            OP_CLEAR: begin
              nodes_used_next = '0;
              cur_node_next   = '0;
              state_next      = S_FINISH;
            end
            OP_INSERT: begin
              cur_node_next   = '0;
              shift_code_next = cmd.code;
              remain_next     = cmd.len;
              ins_sym_next    = cmd.symbol;
              walk_node_next  = '0;
              // Create the root on an empty tree
              if (nodes_used == '0) begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wdata       = ROOT_BLANK;
                root_entry_next = ROOT_BLANK;
                walk_entry_next = ROOT_BLANK;
                nodes_used_next = CNT_W'(1);
              end else begin
                walk_entry_next = root_entry;
              end
              state_next = S_INS_STEP;
            end
            OP_DECODE: begin
              if (nodes_used == '0 || child == '0) begin
                res_next.status = ST_BAD_PATH;
                cur_node_next   = '0;
                state_next      = S_FINISH;
              end else begin
                ram_re         = 1'b1;
                ram_raddr      = child;
                dec_child_next = child;
                state_next     = S_DEC_RD;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end

      S_INS_STEP: begin
        if (remain == '0) begin
          state_next = S_FINISH;
        end else if (slot != '0) begin
          // Follow an existing child
          ram_re          = 1'b1;
          ram_raddr       = slot;
          walk_node_next  = slot;
          shift_code_next = shift_code << 1;
          remain_next     = remain - LEN_W'(1);
          state_next      = S_INS_RD;
        end else if (nodes_used == CNT_W'(MAX_NODES)) begin
          res_next.status = ST_FULL;
          state_next      = S_FINISH;
        end else begin
          // Create the child now, link it into its parent next cycle
          ram_we          = 1'b1;
          ram_waddr       = new_idx;
          ram_wdata       = fresh;
          nodes_used_next = nodes_used + CNT_W'(1);
          link_entry_next = walk_entry;
          if (step_bit) begin
            link_entry_next.right = new_idx;
          end else begin
            link_entry_next.left = new_idx;
          end
          link_addr_next  = walk_node;
          walk_entry_next = fresh;
          walk_node_next  = new_idx;
          shift_code_next = shift_code << 1;
          remain_next     = remain - LEN_W'(1);
          state_next      = S_INS_LINK;
        end
      end

      S_INS_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = link_addr;
        ram_wdata = link_entry;
        if (link_addr == '0) begin
          root_entry_next = link_entry;
        end
        state_next = S_INS_STEP;
      end

      S_INS_RD: begin
        walk_entry_next = rd_entry;
        state_next      = S_INS_STEP;
      end

      S_DEC_RD: begin
        // A node with no children is a leaf: emit and return to the root
        if (rd_entry.left == '0 && rd_entry.right == '0) begin
          res_next.symbol_valid   = 1'b1;
          res_next.decoded_symbol = rd_entry.sym;
          cur_node_next           = '0;
        end else begin
          cur_node_next  = dec_child;
          cur_entry_next = rd_entry;
        end
        state_next = S_FINISH;
      end

      S_FINISH: begin
        // Hand the result over once the output register is free
        if (!out_valid || result.ready) begin
          out_valid_next = 1'b1;
          out_res_next   = res_next;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= '0;
      cur_node   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      cur_node   <= cur_node_next;
      out_valid  <= out_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cur_entry  <= cur_entry_next;
    root_entry <= root_entry_next;
    walk_entry <= walk_entry_next;
    walk_node  <= walk_node_next;
    link_entry <= link_entry_next;
    link_addr  <= link_addr_next;
    shift_code <= shift_code_next;
    remain     <= remain_next;
    ins_sym    <= ins_sym_next;
    dec_child  <= dec_child_next;
    res        <= res_next;
    out_res    <= out_res_next;
  end

  // Node count never exceeds the store
  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= CNT_W'(MAX_NODES))
    else $error("node count beyond store size");

  // The current node is always a created node
  a_cur_created: assert property (@(posedge clk) disable iff (rst)
    nodes_used != '0 |-> CNT_W'(cur_node) < nodes_used)
    else $error("current node not created");

  // A parent link only targets a created node
  a_link_target: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_LINK |-> CNT_W'(link_addr) < nodes_used)
    else $error("link write to uncreated node");

  // A decoded symbol always comes with good status
  a_sym_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.symbol_valid |-> out_res.status == ST_OK)
    else $error("symbol emitted with error status");

endmodule

`default_nettype wire

// File: hdl/huffman_tree_decoder.sv
// huffman_tree_decoder: Huffman decoder walking a code tree in a node RAM.
// Decode reads the child node (an error skips the read), clear and unused codes go
// straight to the result, and insert reads or creates and links a node per code bit.
// One word is in the back-end sequencer at a time; the two-word queue and the
// result register let input and output stall apart.
// Synchronous reset empties the tree and the queue; no clearing pass is needed.
`default_nettype none

module huffman_tree_decoder (
  input  logic     clk,
  input  logic     rst,
  hd_in_if.sink    item,
  hd_out_if.source result
);
  import hd_pkg::*;

  logic push;
  logic queue_full;
  cmd_t front_cmd;
  logic pop;
  logic cmd_valid;
  cmd_t cmd;

  hd_front u_front (
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  hd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (cmd_valid),
    .pop_cmd   (cmd)
  );

  hd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire
